// ===== hdl/sdf_pkg.sv =====
package sdf_pkg;

  // Width of one timestamp or version value.
  localparam int KEY_W = 64;

  // Width of one stored skyline point: timestamp in the upper half, version in the lower.
  localparam int ENTRY_W = 2 * KEY_W;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [1:0] opcode_t;

  // Operation codes carried by each input word.
  localparam opcode_t OP_CLEAR  = 2'd0;
  localparam opcode_t OP_APPEND = 2'd1;
  localparam opcode_t OP_QUERY  = 2'd2;

endpackage

// ===== hdl/sdf_ram.sv =====
module sdf_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/skyline_delete_filter_top.sv =====
// Clear and append words produce no result word.
// A query with a zero pointer goes straight to the done state; otherwise it passes through the
// read and compare states for each segment, moving the pointer down after each memory read
// until a segment decides it. One word is worked on at a time; after a query the next word is
// accepted once the result is loaded into the output register, which raises out_valid.
// Reset (synchronous, active low) clears the skyline, walk pointer, state and out_valid only.
module skyline_delete_filter_top #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sdf_pkg::opcode_t in_opcode,
  input  sdf_pkg::key_t    in_key_ts,
  input  sdf_pkg::key_t    in_key_version,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_deleted
);

  import sdf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [PW-1:0]      ptr_r, ptr_nxt;
  key_t               key_ts_r, key_ts_nxt;
  key_t               key_ver_r, key_ver_nxt;
  logic               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_deleted_r, out_deleted_nxt;

  logic               accept;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;
  logic [PW-1:0]      lo_addr;
  logic [ENTRY_W-1:0] up_q, lo_q;
  key_t               up_ts, up_ver, lo_ts, lo_ver;
  logic               key_above, lo_hit, up_hit;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // An append writes the same point into both copies of the skyline.
  assign wr_en   = accept && (in_opcode == OP_APPEND) && (count_r < CW'(DEPTH));
  assign wr_data = {in_key_ts, in_key_version};
  assign lo_addr = ptr_r - 1'b1;

  // Two copies let the upper and the lower point of a segment be read in the same cycle.
  sdf_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_up_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[PW-1:0]),
    .wdata (wr_data),
    .raddr (ptr_r),
    .rdata (up_q)
  );

  sdf_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_lo_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[PW-1:0]),
    .wdata (wr_data),
    .raddr (lo_addr),
    .rdata (lo_q)
  );

  assign up_ts  = up_q[ENTRY_W-1:KEY_W];
  assign up_ver = up_q[KEY_W-1:0];
  assign lo_ts  = lo_q[ENTRY_W-1:KEY_W];
  assign lo_ver = lo_q[KEY_W-1:0];

  // Segment tests, all signed.
  assign key_above = key_ts_r > up_ts;
  assign lo_hit    = (lo_ts <= key_ts_r) && (key_ver_r <= lo_ver);
  assign up_hit    = (lo_ts <= key_ts_r) && (key_ts_r == up_ts) && (key_ver_r <= up_ver);

  // Sequencer for one word at a time.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    ptr_nxt         = ptr_r;
    key_ts_nxt      = key_ts_r;
    key_ver_nxt     = key_ver_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_deleted_nxt = out_deleted_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_CLEAR: begin
              count_nxt = '0;
              ptr_nxt   = '0;
            end
            OP_APPEND: begin
              if (wr_en) begin
                ptr_nxt   = count_r[PW-1:0];
                count_nxt = count_r + 1'b1;
              end
            end
            OP_QUERY: begin
              key_ts_nxt  = in_key_ts;
              key_ver_nxt = in_key_version;
              res_nxt     = 1'b0;
              if (ptr_r == '0) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // The memories are reading the segment at the pointer.
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (key_above) begin
          res_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else if (lo_hit || up_hit) begin
          res_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (ptr_r > PW'(1)) begin
          ptr_nxt   = ptr_r - 1'b1;
          state_nxt = ST_READ;
        end else begin
          res_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_deleted_nxt = res_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_ts_r      <= key_ts_nxt;
    key_ver_r     <= key_ver_nxt;
    res_r         <= res_nxt;
    out_deleted_r <= out_deleted_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_deleted = out_deleted_r;

endmodule
